### hw/rtl/htw_pkg.sv
`default_nettype none
package htw_pkg;

  localparam int MAX_CONNS_DEF  = 64;
  localparam int SLOT_COUNT_DEF = 32;

  localparam int TIME_W     = 64;
  localparam int CONN_W     = 6;
  localparam int COUNT_W    = 7;
  localparam int SLOT_W_MAX = 10;
  localparam int RES_N_W    = 11;

  localparam int SLOT_SPAN_US = 1000000;
  localparam int REM_W        = 20;

  localparam logic [TIME_W-1:0] NO_TIMER = '1;

  typedef enum logic [1:0] {
    OP_UPD   = 2'd0,
    OP_REM   = 2'd1,
    OP_SWEEP = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic [CONN_W-1:0]     conn;
    logic [TIME_W-1:0]     tval;
    logic [SLOT_W_MAX-1:0] slot;
  } cmd_t;

  typedef struct packed {
    logic                next_valid;
    logic [CONN_W-1:0]   next_conn;
    logic [TIME_W-1:0]   next_expiry;
    logic [COUNT_W-1:0]  active_count;
  } status_t;

  typedef struct packed {
    logic               done;
    logic [RES_N_W-1:0] n;
    status_t            status;
  } done_t;

endpackage
`default_nettype wire

### hw/rtl/hashed_timer_wheel_unit.sv
`default_nettype none
// Channel | Direction | Handshake           | Word
// in_     | input     | in_push / in_full   | kind, conn_id, expiry_time, now_time
// out_    | output    | out_empty / out_pop | expired_valid/conn, last, next_*, count
//
// An update with a real expiry first passes the front for the slot division
// (per 16-bit digit of the shifted time: estimate, fix, modular add, modular
// estimate, modular fix), then the back unlinks it if linked, walks back in the
// slot list and links it, and searches the slots again for the earliest entry
// when needed. A sweep drains every slot of expired connections, then searches.
// After reset the back clears the slot table, with full high.
// The back starts an item only once every word of the previous one was popped;
// a two-deep command queue lets the front keep accepting meanwhile.
module hashed_timer_wheel_unit #(
  parameter int MAX_CONNS  = htw_pkg::MAX_CONNS_DEF,
  parameter int SLOT_COUNT = htw_pkg::SLOT_COUNT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  output      logic                          in_full,
  input  wire logic [1:0]                    in_kind,
  input  wire logic [htw_pkg::CONN_W-1:0]    in_conn_id,
  input  wire logic [htw_pkg::TIME_W-1:0]    in_expiry_time,
  input  wire logic [htw_pkg::TIME_W-1:0]    in_now_time,
  output      logic                          out_empty,
  input  wire logic                          out_pop,
  output      logic                          out_expired_valid,
  output      logic [htw_pkg::CONN_W-1:0]    out_expired_conn,
  output      logic                          out_last,
  output      logic                          out_next_valid,
  output      logic [htw_pkg::CONN_W-1:0]    out_next_conn,
  output      logic [htw_pkg::TIME_W-1:0]    out_next_expiry,
  output      logic [htw_pkg::COUNT_W-1:0]   out_active_count
);
  import htw_pkg::*;

  localparam int CW = $clog2(MAX_CONNS);
  localparam int NW = $clog2(MAX_CONNS + 1);

  logic          clearing;
  logic          q_full, q_push, q_empty, q_pop;
  cmd_t          q_in, q_out;
  logic          out_busy;
  logic          res_push;
  logic [NW-1:0] res_idx;
  logic [CW-1:0] res_conn;
  done_t         done;

  htw_front #(.MAXC(MAX_CONNS), .SC(SLOT_COUNT)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_kind        (in_kind),
    .in_conn_id     (in_conn_id),
    .in_expiry_time (in_expiry_time),
    .in_now_time    (in_now_time),
    .clearing       (clearing),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_in)
  );

  htw_cmdq u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (q_out)
  );

  htw_back #(.MAXC(MAX_CONNS), .SC(SLOT_COUNT), .CW(CW), .NW(NW)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cq_empty (q_empty),
    .cq_pop   (q_pop),
    .cq_data  (q_out),
    .clearing (clearing),
    .out_busy (out_busy),
    .res_push (res_push),
    .res_idx  (res_idx),
    .res_conn (res_conn),
    .done     (done)
  );

  htw_out #(.MAXC(MAX_CONNS), .CW(CW), .NW(NW)) u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .res_push          (res_push),
    .res_idx           (res_idx),
    .res_conn          (res_conn),
    .done              (done),
    .busy              (out_busy),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_expired_valid (out_expired_valid),
    .out_expired_conn  (out_expired_conn),
    .out_last          (out_last),
    .out_next_valid    (out_next_valid),
    .out_next_conn     (out_next_conn),
    .out_next_expiry   (out_next_expiry),
    .out_active_count  (out_active_count)
  );

endmodule
`default_nettype wire

### hw/rtl/htw_front.sv
`default_nettype none
module htw_front #(
  parameter int MAXC = 64,
  parameter int SC   = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_push,
  output      logic                         in_full,
  input  wire logic [1:0]                   in_kind,
  input  wire logic [htw_pkg::CONN_W-1:0]   in_conn_id,
  input  wire logic [htw_pkg::TIME_W-1:0]   in_expiry_time,
  input  wire logic [htw_pkg::TIME_W-1:0]   in_now_time,
  input  wire logic                         clearing,
  input  wire logic                         q_full,
  output      logic                         q_push,
  output      htw_pkg::cmd_t                q_data
);
  import htw_pkg::*;

  localparam int SW = (SC > 1) ? $clog2(SC) : 1;

  localparam logic [1:0] KIND_UPDATE = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_SWEEP  = 2'd2;

  // floor(t / 1e6) == floor((t >> 6) / 15625): divide the shifted time by
  // 15625 one 16-bit digit at a time with a reciprocal multiply per digit
  localparam int SPAN_SHIFT = 6;
  localparam int SPAN_ODD   = SLOT_SPAN_US >> SPAN_SHIFT;
  localparam int ODD_W      = 14;
  localparam int DIG_W      = 16;
  localparam int X_W        = ODD_W + DIG_W;
  localparam int QK         = 44;
  localparam int QM_W       = 31;
  localparam logic [QM_W-1:0] QM = QM_W'((64'd1 << QK) / 64'(SPAN_ODD));

  // quotient kept modulo the slot count, reduced once per digit
  localparam int VW  = 21;
  localparam int MK  = 22;
  localparam int MMW = 23;
  localparam int R16 = (1 << DIG_W) % SC;
  localparam logic [MMW-1:0] MM = MMW'((64'd1 << MK) / 64'(SC));

  typedef enum logic [6:0] {
    F_IDLE = 7'b0000001,
    F_QEST = 7'b0000010,
    F_QFIX = 7'b0000100,
    F_MADD = 7'b0001000,
    F_MEST = 7'b0010000,
    F_MFIX = 7'b0100000,
    F_PUSH = 7'b1000000
  } fstate_t;

  fstate_t           state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [ODD_W-1:0]  rem_r, rem_nxt;
  logic [SW-1:0]     qm_r, qm_nxt;
  logic [1:0]        dig_r, dig_nxt;
  logic [X_W-1:0]    x_r, x_nxt;
  logic [DIG_W-1:0]  qe_r, qe_nxt;
  logic [DIG_W-1:0]  qd_r, qd_nxt;
  logic [VW-1:0]     v_r, v_nxt;
  logic [VW-1:0]     me_r, me_nxt;

  logic                  accept;
  logic                  cid_ok;
  op_t                   op_in;
  logic [TIME_W-1:0]     tshift;
  logic [DIG_W-1:0]      digit;
  logic [X_W-1:0]        x_cur;
  logic [X_W+QM_W-1:0]   qprod;
  logic [X_W-1:0]        r_fix;
  logic                  r_ge;
  logic [VW+MMW-1:0]     mprod;
  logic [VW-1:0]         m_fix;
  logic                  m_ge;

  assign in_full = (state_r != F_IDLE) || clearing;
  assign accept  = in_push && !in_full;
  assign cid_ok  = int'(in_conn_id) < MAXC;
  assign q_push  = (state_r == F_PUSH) && !q_full;
  assign q_data  = cmd_r;

  assign tshift = cmd_r.tval >> SPAN_SHIFT;
  assign digit  = tshift[int'(dig_r) * DIG_W +: DIG_W];
  assign x_cur  = {rem_r, digit};
  assign qprod  = (X_W+QM_W)'(x_cur) * (X_W+QM_W)'(QM);
  assign r_fix  = x_r - X_W'(qe_r) * X_W'(SPAN_ODD);
  assign r_ge   = r_fix >= X_W'(SPAN_ODD);
  assign mprod  = (VW+MMW)'(v_r) * (VW+MMW)'(MM);
  assign m_fix  = v_r - me_r * VW'(SC);
  assign m_ge   = m_fix >= VW'(SC);

  always_comb begin
    case (in_kind)
      KIND_UPDATE: op_in = cid_ok ? OP_UPD : OP_NOP;
      KIND_REMOVE: op_in = cid_ok ? OP_REM : OP_NOP;
      KIND_SWEEP:  op_in = OP_SWEEP;
      default:     op_in = OP_NOP;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    rem_nxt   = rem_r;
    qm_nxt    = qm_r;
    dig_nxt   = dig_r;
    x_nxt     = x_r;
    qe_nxt    = qe_r;
    qd_nxt    = qd_r;
    v_nxt     = v_r;
    me_nxt    = me_r;
    case (state_r)
      F_IDLE: begin
        rem_nxt = '0;
        qm_nxt  = '0;
        dig_nxt = 2'd3;
        if (accept) begin
          cmd_nxt.op   = op_in;
          cmd_nxt.conn = in_conn_id;
          cmd_nxt.tval = (in_kind == KIND_SWEEP) ? in_now_time : in_expiry_time;
          cmd_nxt.slot = '0;
          if (op_in == OP_UPD && in_expiry_time != NO_TIMER) state_nxt = F_QEST;
          else state_nxt = F_PUSH;
        end
      end
      // estimate may come out one low, fixed next cycle
      F_QEST: begin
        x_nxt     = x_cur;
        qe_nxt    = qprod[QK +: DIG_W];
        state_nxt = F_QFIX;
      end
      F_QFIX: begin
        qd_nxt    = r_ge ? qe_r + DIG_W'(1) : qe_r;
        rem_nxt   = r_ge ? ODD_W'(r_fix - X_W'(SPAN_ODD)) : ODD_W'(r_fix);
        state_nxt = F_MADD;
      end
      F_MADD: begin
        v_nxt     = VW'(qm_r) * VW'(R16) + VW'(qd_r);
        state_nxt = F_MEST;
      end
      F_MEST: begin
        me_nxt    = mprod[MK +: VW];
        state_nxt = F_MFIX;
      end
      F_MFIX: begin
        qm_nxt = m_ge ? SW'(m_fix - VW'(SC)) : SW'(m_fix);
        if (dig_r == 2'd0) begin
          cmd_nxt.slot = SLOT_W_MAX'(qm_nxt);
          state_nxt    = F_PUSH;
        end else begin
          dig_nxt   = dig_r - 2'd1;
          state_nxt = F_QEST;
        end
      end
      F_PUSH: begin
        if (!q_full) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    rem_r <= rem_nxt;
    qm_r  <= qm_nxt;
    dig_r <= dig_nxt;
    x_r   <= x_nxt;
    qe_r  <= qe_nxt;
    qd_r  <= qd_nxt;
    v_r   <= v_nxt;
    me_r  <= me_nxt;
  end

endmodule
`default_nettype wire

### hw/rtl/htw_cmdq.sv
`default_nettype none
module htw_cmdq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire htw_pkg::cmd_t push_data,
  output      logic          full,
  input  wire logic          pop,
  output      logic          empty,
  output      htw_pkg::cmd_t pop_data
);
  import htw_pkg::*;

  cmd_t       slots_r [2];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full     = cnt_r == 2'd2;
  assign empty    = cnt_r == 2'd0;
  assign pop_data = slots_r[rd_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_nxt  = do_push ? ~wr_r : wr_r;
    rd_nxt  = do_pop ? ~rd_r : rd_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots_r[wr_r] <= push_data;
  end

endmodule
`default_nettype wire

### hw/rtl/htw_back.sv
`default_nettype none
module htw_back #(
  parameter int MAXC = 64,
  parameter int SC   = 32,
  parameter int CW   = $clog2(MAXC),
  parameter int NW   = $clog2(MAXC + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cq_empty,
  output      logic          cq_pop,
  input  wire htw_pkg::cmd_t cq_data,
  output      logic          clearing,
  input  wire logic          out_busy,
  output      logic          res_push,
  output      logic [NW-1:0] res_idx,
  output      logic [CW-1:0] res_conn,
  output      htw_pkg::done_t done
);
  import htw_pkg::*;

  localparam int SW = (SC > 1) ? $clog2(SC) : 1;
  localparam int HW = CW + 1;
  localparam logic [HW-1:0] NONE_V = {1'b1, {CW{1'b0}}};
  localparam logic [SW-1:0] SLOT_LAST = SW'(SC - 1);

  typedef enum logic [20:0] {
    ST_CLR   = 21'd1 << 0,
    ST_IDLE  = 21'd1 << 1,
    ST_TO_A  = 21'd1 << 2,
    ST_TO_B  = 21'd1 << 3,
    ST_TO_C  = 21'd1 << 4,
    ST_PI_A  = 21'd1 << 5,
    ST_PI_B  = 21'd1 << 6,
    ST_PI_C  = 21'd1 << 7,
    ST_PI_D  = 21'd1 << 8,
    ST_PI_L1 = 21'd1 << 9,
    ST_PI_L2 = 21'd1 << 10,
    ST_FE_A  = 21'd1 << 11,
    ST_FE_B  = 21'd1 << 12,
    ST_FE_C  = 21'd1 << 13,
    ST_SW_A  = 21'd1 << 14,
    ST_SW_B  = 21'd1 << 15,
    ST_SW_C  = 21'd1 << 16,
    ST_UPD2  = 21'd1 << 17,
    ST_UPD3  = 21'd1 << 18,
    ST_REM2  = 21'd1 << 19,
    ST_DONE  = 21'd1 << 20
  } bstate_t;

  // linked-list stores
  logic [TIME_W-1:0] exp_mem  [MAXC];
  logic [SW-1:0]     slot_mem [MAXC];
  logic [CW-1:0]     fwd_mem  [MAXC];
  logic [CW-1:0]     bwd_mem  [MAXC];
  logic [HW-1:0]     head_mem [SC];
  logic [HW-1:0]     tail_mem [SC];

  logic [TIME_W-1:0] exp_q;
  logic [SW-1:0]     slot_q;
  logic [CW-1:0]     fwd_q, bwd_q;
  logic [HW-1:0]     head_q, tail_q;

  logic [CW-1:0] exp_ra, link_ra;
  logic [SW-1:0] ht_ra;
  logic          exp_we, slot_we;
  logic          fwd_we, bwd_we, head_we, tail_we;
  logic [CW-1:0] fwd_wa, fwd_wd, bwd_wa, bwd_wd;
  logic [SW-1:0] head_wa, tail_wa;
  logic [HW-1:0] head_wd, tail_wd;

  bstate_t           state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [CW-1:0]     cur_r, cur_nxt;
  logic [TIME_W-1:0] t_r, t_nxt;
  logic [SW-1:0]     ps_r, ps_nxt;
  logic [SW-1:0]     ts_r, ts_nxt;
  logic [SW-1:0]     sc_r, sc_nxt;
  logic [SW-1:0]     clr_r, clr_nxt;
  logic              was_r, was_nxt;
  logic [CW-1:0]     h_r, h_nxt;
  logic [HW-1:0]     e_r, e_nxt;
  logic [HW-1:0]     head_r, head_nxt;
  logic [HW-1:0]     tail_r, tail_nxt;
  logic [HW-1:0]     nx_r, nx_nxt;
  logic [CW-1:0]     tb_r, tb_nxt;
  logic [CW-1:0]     tf_r, tf_nxt;
  logic [MAXC-1:0]   linked_r, linked_nxt;
  logic [NW-1:0]     count_r, count_nxt;
  logic [TIME_W-1:0] et_r, et_nxt;
  logic [CW-1:0]     ec_r, ec_nxt;
  logic              ecv_r, ecv_nxt;
  logic [NW-1:0]     n_r, n_nxt;

  logic          fe_go, sw_adv, fe_adv;
  logic          prev_none, next_none;
  logic [CW-1:0] cq_cid;

  assign clearing = state_r == ST_CLR;
  assign cq_cid   = CW'(cq_data.conn);
  assign prev_none = head_q == {1'b0, cur_r};
  assign next_none = tail_q == {1'b0, cur_r};

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    cur_nxt    = cur_r;
    t_nxt      = t_r;
    ps_nxt     = ps_r;
    ts_nxt     = ts_r;
    sc_nxt     = sc_r;
    clr_nxt    = clr_r;
    was_nxt    = was_r;
    h_nxt      = h_r;
    e_nxt      = e_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    nx_nxt     = nx_r;
    tb_nxt     = tb_r;
    tf_nxt     = tf_r;
    linked_nxt = linked_r;
    count_nxt  = count_r;
    et_nxt     = et_r;
    ec_nxt     = ec_r;
    ecv_nxt    = ecv_r;
    n_nxt      = n_r;

    exp_ra  = cur_r;
    link_ra = cur_r;
    ht_ra   = ps_r;
    exp_we  = 1'b0;
    slot_we = 1'b0;
    fwd_we  = 1'b0;
    bwd_we  = 1'b0;
    head_we = 1'b0;
    tail_we = 1'b0;
    fwd_wa  = cur_r;
    fwd_wd  = cur_r;
    bwd_wa  = cur_r;
    bwd_wd  = cur_r;
    head_wa = ps_r;
    tail_wa = ps_r;
    head_wd = NONE_V;
    tail_wd = NONE_V;

    cq_pop   = 1'b0;
    res_push = 1'b0;
    res_idx  = n_r;
    res_conn = h_r;
    done     = '0;

    fe_go  = 1'b0;
    sw_adv = 1'b0;
    fe_adv = 1'b0;

    case (state_r)
      ST_CLR: begin
        head_we = 1'b1;
        tail_we = 1'b1;
        head_wa = clr_r;
        tail_wa = clr_r;
        if (clr_r == SLOT_LAST) state_nxt = ST_IDLE;
        else clr_nxt = clr_r + SW'(1);
      end
      ST_IDLE: begin
        if (!cq_empty && !out_busy) begin
          cq_pop  = 1'b1;
          op_nxt  = cq_data.op;
          cur_nxt = cq_cid;
          t_nxt   = cq_data.tval;
          ps_nxt  = cq_data.slot[SW-1:0];
          was_nxt = linked_r[cq_cid];
          n_nxt   = '0;
          case (cq_data.op)
            OP_SWEEP: begin
              sc_nxt    = '0;
              state_nxt = ST_SW_A;
            end
            OP_UPD:  state_nxt = linked_r[cq_cid] ? ST_TO_A : ST_UPD2;
            OP_REM:  state_nxt = linked_r[cq_cid] ? ST_TO_A : ST_DONE;
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      // unlink cur_r from its slot list
      ST_TO_A: state_nxt = ST_TO_B;
      ST_TO_B: begin
        ts_nxt    = slot_q;
        tb_nxt    = bwd_q;
        tf_nxt    = fwd_q;
        ht_ra     = slot_q;
        state_nxt = ST_TO_C;
      end
      ST_TO_C: begin
        if (prev_none) begin
          head_we = 1'b1;
          head_wa = ts_r;
          head_wd = next_none ? NONE_V : {1'b0, tf_r};
        end else begin
          fwd_we = 1'b1;
          fwd_wa = tb_r;
          fwd_wd = tf_r;
        end
        if (next_none) begin
          tail_we = 1'b1;
          tail_wa = ts_r;
          tail_wd = prev_none ? NONE_V : {1'b0, tb_r};
        end else begin
          bwd_we = 1'b1;
          bwd_wa = tf_r;
          bwd_wd = tb_r;
        end
        linked_nxt[cur_r] = 1'b0;
        case (op_r)
          OP_SWEEP: state_nxt = ST_SW_A;
          OP_UPD:   state_nxt = ST_UPD2;
          default:  state_nxt = ST_REM2;
        endcase
      end
      ST_REM2: begin
        count_nxt = count_r - NW'(1);
        if (ecv_r && ec_r == cur_r) fe_go = 1'b1;
        else state_nxt = ST_DONE;
      end
      ST_UPD2: begin
        if (t_r == NO_TIMER) begin
          if (was_r) count_nxt = count_r - NW'(1);
          if (ecv_r && ec_r == cur_r) fe_go = 1'b1;
          else state_nxt = ST_DONE;
        end else begin
          if (!was_r) count_nxt = count_r + NW'(1);
          state_nxt = ST_PI_A;
        end
      end
      // walk back from the tail to the last entry that expires earlier
      ST_PI_A: state_nxt = ST_PI_B;
      ST_PI_B: begin
        head_nxt  = head_q;
        tail_nxt  = tail_q;
        e_nxt     = tail_q;
        state_nxt = ST_PI_C;
      end
      ST_PI_C: begin
        if (e_r[CW]) begin
          nx_nxt    = head_r;
          state_nxt = ST_PI_L1;
        end else begin
          exp_ra    = e_r[CW-1:0];
          link_ra   = e_r[CW-1:0];
          state_nxt = ST_PI_D;
        end
      end
      ST_PI_D: begin
        if (t_r > exp_q) begin
          nx_nxt    = (e_r == tail_r) ? NONE_V : {1'b0, fwd_q};
          state_nxt = ST_PI_L1;
        end else begin
          e_nxt     = (e_r == head_r) ? NONE_V : {1'b0, bwd_q};
          state_nxt = ST_PI_C;
        end
      end
      ST_PI_L1: begin
        exp_we  = 1'b1;
        slot_we = 1'b1;
        if (e_r[CW]) begin
          head_we = 1'b1;
          head_wd = {1'b0, cur_r};
        end else begin
          fwd_we = 1'b1;
          fwd_wa = e_r[CW-1:0];
          fwd_wd = cur_r;
          bwd_we = 1'b1;
          bwd_wa = cur_r;
          bwd_wd = e_r[CW-1:0];
        end
        state_nxt = ST_PI_L2;
      end
      ST_PI_L2: begin
        if (nx_r[CW]) begin
          tail_we = 1'b1;
          tail_wd = {1'b0, cur_r};
        end else begin
          fwd_we = 1'b1;
          fwd_wa = cur_r;
          fwd_wd = nx_r[CW-1:0];
          bwd_we = 1'b1;
          bwd_wa = nx_r[CW-1:0];
          bwd_wd = cur_r;
        end
        linked_nxt[cur_r] = 1'b1;
        state_nxt = ST_UPD3;
      end
      ST_UPD3: begin
        if (t_r < et_r) begin
          et_nxt    = t_r;
          ec_nxt    = cur_r;
          ecv_nxt   = 1'b1;
          state_nxt = ST_DONE;
        end else if (ecv_r && ec_r == cur_r) begin
          fe_go = 1'b1;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      // scan slot heads for the earliest expiry
      ST_FE_A: begin
        ht_ra     = sc_r;
        state_nxt = ST_FE_B;
      end
      ST_FE_B: begin
        if (head_q[CW]) begin
          fe_adv = 1'b1;
        end else begin
          h_nxt     = head_q[CW-1:0];
          exp_ra    = head_q[CW-1:0];
          state_nxt = ST_FE_C;
        end
      end
      ST_FE_C: begin
        if (exp_q < et_r) begin
          et_nxt  = exp_q;
          ec_nxt  = h_r;
          ecv_nxt = 1'b1;
        end
        fe_adv = 1'b1;
      end
      // drain each slot from its head while expired
      ST_SW_A: begin
        ht_ra     = sc_r;
        state_nxt = ST_SW_B;
      end
      ST_SW_B: begin
        if (head_q[CW]) begin
          sw_adv = 1'b1;
        end else begin
          h_nxt     = head_q[CW-1:0];
          exp_ra    = head_q[CW-1:0];
          state_nxt = ST_SW_C;
        end
      end
      ST_SW_C: begin
        if (exp_q > t_r) begin
          sw_adv = 1'b1;
        end else begin
          res_push  = 1'b1;
          n_nxt     = n_r + NW'(1);
          count_nxt = count_r - NW'(1);
          cur_nxt   = h_r;
          state_nxt = ST_TO_A;
        end
      end
      ST_DONE: begin
        done.done                = 1'b1;
        done.n                   = RES_N_W'(n_r);
        done.status.next_valid   = ecv_r;
        done.status.next_conn    = ecv_r ? CONN_W'(ec_r) : '0;
        done.status.next_expiry  = ecv_r ? et_r : NO_TIMER;
        done.status.active_count = COUNT_W'(count_r);
        state_nxt                = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (sw_adv) begin
      if (sc_r == SLOT_LAST) begin
        fe_go = 1'b1;
      end else begin
        sc_nxt    = sc_r + SW'(1);
        state_nxt = ST_SW_A;
      end
    end
    if (fe_adv) begin
      if (sc_r == SLOT_LAST) begin
        state_nxt = ST_DONE;
      end else begin
        sc_nxt    = sc_r + SW'(1);
        state_nxt = ST_FE_A;
      end
    end
    if (fe_go) begin
      sc_nxt    = '0;
      et_nxt    = NO_TIMER;
      ecv_nxt   = 1'b0;
      state_nxt = ST_FE_A;
    end
  end

  always_ff @(posedge clk) begin
    exp_q  <= exp_mem[exp_ra];
    slot_q <= slot_mem[link_ra];
    fwd_q  <= fwd_mem[link_ra];
    bwd_q  <= bwd_mem[link_ra];
    head_q <= head_mem[ht_ra];
    tail_q <= tail_mem[ht_ra];
    if (exp_we)  exp_mem[cur_r]    <= t_r;
    if (slot_we) slot_mem[cur_r]   <= ps_r;
    if (fwd_we)  fwd_mem[fwd_wa]   <= fwd_wd;
    if (bwd_we)  bwd_mem[bwd_wa]   <= bwd_wd;
    if (head_we) head_mem[head_wa] <= head_wd;
    if (tail_we) tail_mem[tail_wa] <= tail_wd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLR;
      clr_r    <= '0;
      linked_r <= '0;
      count_r  <= '0;
      et_r     <= NO_TIMER;
      ec_r     <= '0;
      ecv_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      linked_r <= linked_nxt;
      count_r  <= count_nxt;
      et_r     <= et_nxt;
      ec_r     <= ec_nxt;
      ecv_r    <= ecv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    cur_r  <= cur_nxt;
    t_r    <= t_nxt;
    ps_r   <= ps_nxt;
    ts_r   <= ts_nxt;
    sc_r   <= sc_nxt;
    was_r  <= was_nxt;
    h_r    <= h_nxt;
    e_r    <= e_nxt;
    head_r <= head_nxt;
    tail_r <= tail_nxt;
    nx_r   <= nx_nxt;
    tb_r   <= tb_nxt;
    tf_r   <= tf_nxt;
    n_r    <= n_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NW'(MAXC))
    else $error("active count above capacity");

  a_earliest_linked: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && ecv_r) |-> linked_r[ec_r])
    else $error("earliest connection not in the wheel");

  a_unlink_linked: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TO_C) |-> linked_r[cur_r])
    else $error("unlinking a connection that is not linked");

  a_result_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (n_r < NW'(MAXC)))
    else $error("result store overflow");

endmodule
`default_nettype wire

### hw/rtl/htw_out.sv
`default_nettype none
module htw_out #(
  parameter int MAXC = 64,
  parameter int CW   = $clog2(MAXC),
  parameter int NW   = $clog2(MAXC + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          res_push,
  input  wire logic [NW-1:0]                 res_idx,
  input  wire logic [CW-1:0]                 res_conn,
  input  wire htw_pkg::done_t                done,
  output      logic                          busy,
  output      logic                          out_empty,
  input  wire logic                          out_pop,
  output      logic                          out_expired_valid,
  output      logic [htw_pkg::CONN_W-1:0]    out_expired_conn,
  output      logic                          out_last,
  output      logic                          out_next_valid,
  output      logic [htw_pkg::CONN_W-1:0]    out_next_conn,
  output      logic [htw_pkg::TIME_W-1:0]    out_next_expiry,
  output      logic [htw_pkg::COUNT_W-1:0]   out_active_count
);
  import htw_pkg::*;

  logic [CW-1:0] res_mem [MAXC];
  logic [CW-1:0] q_r;

  logic          busy_r, busy_nxt;
  logic [NW-1:0] rd_r, rd_nxt;
  logic [NW-1:0] n_r;
  status_t       st_r;
  logic          popped, is_last;

  assign busy      = busy_r;
  assign out_empty = !busy_r;
  assign is_last   = (n_r == '0) || (rd_r == n_r - NW'(1));
  assign popped    = out_pop && busy_r;

  always_comb begin
    busy_nxt = busy_r;
    rd_nxt   = rd_r;
    if (done.done) begin
      busy_nxt = 1'b1;
      rd_nxt   = '0;
    end else if (popped) begin
      if (is_last) busy_nxt = 1'b0;
      else rd_nxt = rd_r + NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rd_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      rd_r   <= rd_nxt;
    end
  end

  // prefetch the word that will be on the ports next cycle
  always_ff @(posedge clk) begin
    if (res_push) res_mem[res_idx[CW-1:0]] <= res_conn;
    q_r <= res_mem[rd_nxt[CW-1:0]];
    if (done.done) begin
      n_r  <= done.n[NW-1:0];
      st_r <= done.status;
    end
  end

  assign out_expired_valid = n_r != '0;
  assign out_expired_conn  = (n_r != '0) ? CONN_W'(q_r) : '0;
  assign out_last          = is_last;
  assign out_next_valid    = st_r.next_valid;
  assign out_next_conn     = st_r.next_conn;
  assign out_next_expiry   = st_r.next_expiry;
  assign out_active_count  = st_r.active_count;

endmodule
`default_nettype wire

### verif/htw_wheel_checker.sv
`timescale 1ns / 100ps
module htw_wheel_checker (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_push,
  input  wire logic                        in_full,
  input  wire logic [1:0]                  in_kind,
  input  wire logic [htw_pkg::CONN_W-1:0]  in_conn_id,
  input  wire logic [htw_pkg::TIME_W-1:0]  in_expiry_time,
  input  wire logic [htw_pkg::TIME_W-1:0]  in_now_time,
  input  wire logic                        out_empty,
  input  wire logic                        out_pop,
  input  wire logic                        out_expired_valid,
  input  wire logic [htw_pkg::CONN_W-1:0]  out_expired_conn,
  input  wire logic                        out_last,
  input  wire logic                        out_next_valid,
  input  wire logic [htw_pkg::CONN_W-1:0]  out_next_conn,
  input  wire logic [htw_pkg::TIME_W-1:0]  out_next_expiry,
  input  wire logic [htw_pkg::COUNT_W-1:0] out_active_count,
  output int                               errors,
  output int                               pending,
  output int                               words_checked,
  output int                               conns_swept
);
  import htw_pkg::*;

  localparam int CONNS = 64;
  localparam int SLOTS = 32;
  localparam int NIL   = -1;

  typedef struct packed {
    logic               expired_valid;
    logic [CONN_W-1:0]  expired_conn;
    logic               last;
    logic               next_valid;
    logic [CONN_W-1:0]  next_conn;
    logic [TIME_W-1:0]  next_expiry;
    logic [COUNT_W-1:0] active_count;
  } wheel_word_t;

  wheel_word_t expected_words[$];

  logic [TIME_W-1:0] conn_expiry [CONNS];
  bit                conn_linked [CONNS];
  int                fwd [CONNS];
  int                bwd [CONNS];
  int                head [SLOTS];
  int                tail [SLOTS];
  logic [TIME_W-1:0] soonest_time;
  int                soonest_conn;
  int                live_total;

  function automatic int slot_of(logic [TIME_W-1:0] t);
    return int'((t / 64'd1000000) % 64'd32);
  endfunction

  function automatic void unlink(int c);
    int s, prev, nxt;
    s = slot_of(conn_expiry[c]);
    prev = (head[s] == c) ? NIL : bwd[c];
    nxt  = (tail[s] == c) ? NIL : fwd[c];
    if (prev == NIL) head[s] = nxt; else fwd[prev] = nxt;
    if (nxt == NIL) tail[s] = prev; else bwd[nxt] = prev;
    conn_linked[c] = 0;
  endfunction

  // walk back from the tail; a new entry lands before equal times
  function automatic void link_sorted(int c, logic [TIME_W-1:0] t);
    int s, e, nxt;
    s = slot_of(t);
    e = tail[s];
    conn_expiry[c] = t;
    while (e != NIL) begin
      if (t > conn_expiry[e]) break;
      e = (e == head[s]) ? NIL : bwd[e];
    end
    if (e == NIL) begin
      nxt = head[s];
      head[s] = c;
    end else begin
      nxt = (e == tail[s]) ? NIL : fwd[e];
      fwd[e] = c;
      bwd[c] = e;
    end
    if (nxt == NIL) begin
      tail[s] = c;
    end else begin
      fwd[c] = nxt;
      bwd[nxt] = c;
    end
    conn_linked[c] = 1;
  endfunction

  function automatic void rescan_soonest();
    soonest_time = NO_TIMER;
    soonest_conn = NIL;
    for (int s = 0; s < SLOTS; s++) begin
      if (head[s] != NIL && conn_expiry[head[s]] < soonest_time) begin
        soonest_time = conn_expiry[head[s]];
        soonest_conn = head[s];
      end
    end
  endfunction

  function automatic void push_word(bit valid, int c, bit lst);
    wheel_word_t w;
    w.expired_valid = valid;
    w.expired_conn  = valid ? CONN_W'(c) : '0;
    w.last          = lst;
    w.next_valid    = soonest_conn != NIL;
    w.next_conn     = (soonest_conn != NIL) ? CONN_W'(soonest_conn) : '0;
    w.next_expiry   = (soonest_conn != NIL) ? soonest_time : NO_TIMER;
    w.active_count  = COUNT_W'(live_total);
    expected_words.push_back(w);
  endfunction

  function automatic void apply_item(op_t op, int c, logic [TIME_W-1:0] t,
                                     logic [TIME_W-1:0] now);
    int swept[$];
    bit was;
    if (op == OP_SWEEP) begin
      for (int s = 0; s < SLOTS; s++) begin
        while (head[s] != NIL) begin
          if (conn_expiry[head[s]] > now) break;
          swept.push_back(head[s]);
          unlink(head[s]);
          live_total--;
        end
      end
      rescan_soonest();
      if (swept.size() == 0) begin
        push_word(0, 0, 1);
      end else begin
        foreach (swept[k]) push_word(1, swept[k], k == swept.size() - 1);
      end
      return;
    end
    was = conn_linked[c];
    if (op == OP_REM) begin
      if (was) begin
        unlink(c);
        live_total--;
        if (c == soonest_conn) rescan_soonest();
      end
    end else if (op == OP_UPD) begin
      if (was) unlink(c);
      if (t == NO_TIMER) begin
        conn_expiry[c] = NO_TIMER;
        if (was) live_total--;
        if (c == soonest_conn) rescan_soonest();
      end else begin
        if (!was) live_total++;
        link_sorted(c, t);
        if (t < soonest_time) begin
          soonest_time = t;
          soonest_conn = c;
        end else if (c == soonest_conn) begin
          rescan_soonest();
        end
      end
    end
    push_word(0, 0, 1);
  endfunction

  always @(posedge clk) begin
    wheel_word_t got, want;
    if (!rst_n) begin
      for (int i = 0; i < CONNS; i++) begin
        conn_expiry[i] = NO_TIMER;
        conn_linked[i] = 0;
      end
      for (int s = 0; s < SLOTS; s++) begin
        head[s] = NIL;
        tail[s] = NIL;
      end
      soonest_time = NO_TIMER;
      soonest_conn = NIL;
      live_total = 0;
      expected_words.delete();
      errors = 0;
      pending = 0;
      words_checked = 0;
      conns_swept = 0;
    end else begin
      if (out_pop && !out_empty) begin
        got = '{out_expired_valid, out_expired_conn, out_last, out_next_valid,
                out_next_conn, out_next_expiry, out_active_count};
        words_checked++;
        if (got.expired_valid) conns_swept++;
        if (expected_words.size() == 0) begin
          errors++;
          if (errors <= 10) $display("%0t: unexpected word %p", $realtime, got);
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: word %0d mismatch", $realtime, words_checked);
              $display("  expected %p", want);
              $display("  actual   %p", got);
            end
          end
        end
      end
      if (in_push && !in_full)
        apply_item(op_t'(in_kind), int'(in_conn_id), in_expiry_time, in_now_time);
      pending = expected_words.size();
    end
  end

endmodule

### verif/hashed_timer_wheel_unit_tb.sv
`timescale 1ns / 100ps
module hashed_timer_wheel_unit_tb;
  import htw_pkg::*;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_push = 0;
  logic               in_full;
  logic [1:0]         in_kind = '0;
  logic [CONN_W-1:0]  in_conn_id = '0;
  logic [TIME_W-1:0]  in_expiry_time = '0;
  logic [TIME_W-1:0]  in_now_time = '0;
  logic               out_empty;
  logic               out_pop = 0;
  logic               out_expired_valid;
  logic [CONN_W-1:0]  out_expired_conn;
  logic               out_last;
  logic               out_next_valid;
  logic [CONN_W-1:0]  out_next_conn;
  logic [TIME_W-1:0]  out_next_expiry;
  logic [COUNT_W-1:0] out_active_count;

  int errors, pending, words_checked, conns_swept;
  int items_sent;
  bit send_busy, pop_busy;
  logic [TIME_W-1:0] wheel_now;
  logic [TIME_W-1:0] last_expiry;

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  hashed_timer_wheel_unit dut (.*);

  htw_wheel_checker u_checker (.*);

  function automatic int draw_gap(bit busy);
    return busy ? $urandom_range(0, 14) : 0;
  endfunction

  task automatic send_item(op_t op, int c, logic [TIME_W-1:0] t, logic [TIME_W-1:0] now);
    int gap;
    gap = draw_gap(send_busy);
    if (gap > 0) begin
      in_push <= 0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1;
    in_kind <= op;
    in_conn_id <= CONN_W'(c);
    in_expiry_time <= t;
    in_now_time <= now;
    do @(posedge clk); while (in_full);
    items_sent++;
  endtask

  // receiver: hold pop high across back-to-back words, drop it for a stall
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      gap = draw_gap(pop_busy);
      if (gap > 0) begin
        out_pop <= 0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1;
      do @(posedge clk); while (out_empty);
    end
  end

  initial begin
    #100ms;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int r, c;
    logic [TIME_W-1:0] t, now;
    send_busy = 1;
    pop_busy = 1;
    items_sent = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;

    send_item(OP_SWEEP, 0, '0, '0);
    send_item(OP_UPD, 0, '0, '0);
    send_item(OP_UPD, 63, NO_TIMER - 1, NO_TIMER);
    send_item(OP_UPD, 1, 64'd5000000, '0);
    send_item(OP_UPD, 2, 64'd5000000, '0);
    send_item(OP_UPD, 3, 64'd5999999, '0);
    send_item(OP_UPD, 4, 64'd37000000, '0);
    send_item(OP_UPD, 5, 64'd4999999, '0);
    send_item(OP_UPD, 1, 64'd5000000, '0);
    send_item(OP_UPD, 0, 64'd6000000, '0);
    send_item(OP_REM, 5, '0, '0);
    send_item(OP_REM, 10, '0, '0);
    send_item(OP_UPD, 11, NO_TIMER, '0);
    send_item(OP_UPD, 3, NO_TIMER, '0);
    send_item(OP_NOP, 7, 64'd123, 64'd456);
    send_item(OP_SWEEP, 0, '0, 64'd4999999);
    send_item(OP_SWEEP, 0, '0, 64'd5000000);
    send_item(OP_UPD, 6, 64'hAAAA_5555_0F0F_F0F0, '0);
    send_item(OP_SWEEP, 0, '0, NO_TIMER);

    wheel_now = 0;
    last_expiry = 64'd1000000;
    for (int i = 0; i < 320; i++) begin
      // alternate stretches of idling and full-rate traffic
      if (i % 40 == 0) begin
        send_busy = $urandom_range(0, 2) != 0;
        pop_busy = $urandom_range(0, 2) != 0;
      end
      if (i == 150) begin
        in_push <= 0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
      end
      r = $urandom_range(0, 99);
      c = $urandom_range(0, 63);
      if (r < 50) begin
        case ($urandom_range(0, 9))
          0: t = NO_TIMER;
          1: t = {$urandom, $urandom};
          2, 3: t = last_expiry;
          default: t = wheel_now + $urandom_range(0, 40000000);
        endcase
        if (t != NO_TIMER) last_expiry = t;
        send_item(OP_UPD, c, t, {$urandom, $urandom});
      end else if (r < 70) begin
        send_item(OP_REM, c, {$urandom, $urandom}, {$urandom, $urandom});
      end else if (r < 95) begin
        wheel_now = wheel_now + $urandom_range(0, 3000000);
        case ($urandom_range(0, 49))
          0: now = NO_TIMER;
          1: now = {$urandom, $urandom};
          default: now = wheel_now;
        endcase
        send_item(OP_SWEEP, c, {$urandom, $urandom}, now);
      end else begin
        send_item(OP_NOP, c, {$urandom, $urandom}, {$urandom, $urandom});
      end
    end
    in_push <= 0;
    @(posedge clk);

    wait (pending == 0);
    repeat (300) @(posedge clk);
    $display("Sent %0d items (updates, removes, sweeps, no-ops), checked %0d words,",
             items_sent, words_checked);
    $display("%0d connections expired by sweeps, with idle and stall gaps on both sides.",
             conns_swept);
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
